// ===== design/lbe_pkg.sv =====
// Shared types and constants for the LED breathe/blink duty-level controller.
// No dependencies; imported by every module of the block.
`default_nettype none

package lbe_pkg;

  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned MS_W    = 8;

  // Timing constants in milliseconds
  localparam logic [COUNT_W-1:0] BLINK_PERIOD_MS = 16'd200;
  localparam logic [COUNT_W-1:0] BREATHE_STEP_MS = 16'd10;
  localparam logic [COUNT_W-1:0] BREATHE_SLOW_ADD_MS = 16'd50;
  localparam logic [COUNT_W-1:0] BREATHE_SLOW_MS = BREATHE_STEP_MS + BREATHE_SLOW_ADD_MS;
  localparam logic [LEVEL_W-1:0] BREATHE_SLOW_BELOW = 8'd20;
  localparam logic [LEVEL_W-1:0] MAX_LEVEL_RESET = 8'd80;

  // Register indexes (paddr[2])
  localparam logic REG_EFFECT_MODE = 1'b0;
  localparam logic REG_MAX_LEVEL   = 1'b1;

  typedef enum logic [1:0] {
    MODE_ON      = 2'd0,
    MODE_OFF     = 2'd1,
    MODE_BLINK   = 2'd2,
    MODE_BREATHE = 2'd3
  } effect_mode_t;

  typedef struct packed {
    effect_mode_t         mode;
    logic [LEVEL_W-1:0]   max_level;
  } lbe_cfg_t;

  typedef struct packed {
    logic                 en;
    logic [LEVEL_W-1:0]   value;
  } lbe_level_load_t;

  typedef struct packed {
    logic [COUNT_W-1:0]   count;
    logic [LEVEL_W-1:0]   level;
    logic                 rising;
  } lbe_state_t;

endpackage

`default_nettype wire

// ===== design/lbe_cfg_regs.sv =====
// Configuration register file with APB-style access.
// Depends on lbe_pkg.
`default_nettype none

module lbe_cfg_regs
  import lbe_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [2:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic      [31:0]      prdata,
  output lbe_cfg_t              cfg,
  output lbe_level_load_t       level_load
);

  effect_mode_t       mode_r;
  logic [LEVEL_W-1:0] max_level_r;
  logic               wr_en;
  effect_mode_t       wr_mode;

  // pready is tied high, so the access phase always completes
  assign wr_en   = psel && penable && pwrite;
  assign wr_mode = effect_mode_t'(pwdata[1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_ON;
      max_level_r <= MAX_LEVEL_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        REG_EFFECT_MODE: mode_r      <= wr_mode;
        REG_MAX_LEVEL:   max_level_r <= pwdata[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // On/off writes reload the level straight away
  always_comb begin
    level_load.en    = 1'b0;
    level_load.value = '0;
    if (wr_en && (paddr[2] == REG_EFFECT_MODE)) begin
      case (wr_mode)
        MODE_ON: begin
          level_load.en    = 1'b1;
          level_load.value = max_level_r;
        end
        MODE_OFF: begin
          level_load.en    = 1'b1;
          level_load.value = '0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_EFFECT_MODE: prdata = {30'd0, mode_r};
      REG_MAX_LEVEL:   prdata = {24'd0, max_level_r};
      default:         prdata = '0;
    endcase
  end

  assign cfg.mode      = mode_r;
  assign cfg.max_level = max_level_r;

endmodule

`default_nettype wire

// ===== design/lbe_step.sv =====
// Next-state logic for one word: saturating ms counter, blink toggle, breathe step.
// Depends on lbe_pkg.
`default_nettype none

module lbe_step
  import lbe_pkg::*;
(
  input  wire lbe_state_t         cur,
  input  wire lbe_cfg_t           cfg,
  input  wire logic [MS_W-1:0]    ms_elapsed,
  output lbe_state_t              nxt,
  output logic                    fired
);

  logic [COUNT_W:0]   sum;
  logic [COUNT_W-1:0] cnt_sat;
  logic [COUNT_W-1:0] wait_ms;
  logic [LEVEL_W-1:0] up_level;
  logic [LEVEL_W-1:0] dn_level;

  assign sum     = {1'b0, cur.count} + {{(COUNT_W+1-MS_W){1'b0}}, ms_elapsed};
  assign cnt_sat = sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];
  assign wait_ms = (cur.level < BREATHE_SLOW_BELOW) ? BREATHE_SLOW_MS : BREATHE_STEP_MS;

  // level above max while rising: held, direction turns
  assign up_level = (cur.level < cfg.max_level) ? cur.level + 8'd1 : cur.level;
  assign dn_level = (cur.level != '0) ? cur.level - 8'd1 : cur.level;

  always_comb begin
    nxt       = cur;
    nxt.count = cnt_sat;
    fired     = 1'b0;
    case (cfg.mode)
      MODE_BLINK: begin
        if (cnt_sat >= BLINK_PERIOD_MS) begin
          nxt.count = '0;
          nxt.level = (cur.level != '0) ? '0 : cfg.max_level;
          fired     = 1'b1;
        end
      end
      MODE_BREATHE: begin
        if (cnt_sat >= wait_ms) begin
          nxt.count = '0;
          fired     = 1'b1;
          if (cur.rising) begin
            nxt.level  = up_level;
            nxt.rising = !(up_level >= cfg.max_level);
          end else begin
            nxt.level  = dn_level;
            nxt.rising = (dn_level == '0);
          end
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/led_breath_blink_effect_core.sv =====
// LED breathe/blink duty-level controller: one duty level per input word, one result per word.
// Each input word carries the milliseconds since the previous word; the block keeps a
// saturating 16-bit elapsed counter, the current level and the breathe direction. Mode and
// max_level sit in an APB-style register file (mode at 0x0, max_level at 0x4); writing
// mode on or off loads max_level or zero into the level at once. Throughput is one word per
// cycle while out_tready allows; words pass the input register, then the result register. The
// per-word update is a 17-bit add with saturation, a compare and an 8-bit step, all between
// the input register and the state/result registers, so consecutive words see each other's
// state without bubbles. The input side keeps accepting while a result waits on out_tready,
// until the input register itself is full. Depends on lbe_pkg, lbe_cfg_regs and lbe_step.
`default_nettype none

module led_breath_blink_effect_core
  import lbe_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,     // [7:0] ms_elapsed
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [7:0]  out_tdata,    // [7:0] duty_level
  output logic      [0:0]  out_tuser,    // [0] level_updated
  // configuration
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);

  lbe_cfg_t           cfg;
  lbe_level_load_t    level_load;
  lbe_state_t         cur;
  lbe_state_t         nxt;
  logic               fired;

  // input register
  logic               in_v_r;
  logic [MS_W-1:0]    in_ms_r;
  // state
  logic [COUNT_W-1:0] count_r;
  logic [LEVEL_W-1:0] level_r;
  logic               rising_r;
  // result register
  logic               out_v_r;
  logic [LEVEL_W-1:0] out_level_r;
  logic               out_upd_r;

  logic               adv;   // result register can take a new word
  logic               go;    // input register word is processed this cycle
  logic               in_acc;

  assign cfg_pready = 1'b1;

  lbe_cfg_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (cfg_psel),
    .penable    (cfg_penable),
    .pwrite     (cfg_pwrite),
    .paddr      (cfg_paddr),
    .pwdata     (cfg_pwdata),
    .prdata     (cfg_prdata),
    .cfg        (cfg),
    .level_load (level_load)
  );

  assign cur.count  = count_r;
  assign cur.level  = level_r;
  assign cur.rising = rising_r;

  lbe_step u_step (
    .cur        (cur),
    .cfg        (cfg),
    .ms_elapsed (in_ms_r),
    .nxt        (nxt),
    .fired      (fired)
  );

  assign adv       = !out_v_r || out_tready;
  assign go        = in_v_r && adv;
  assign in_tready = !in_v_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_acc) begin
      in_v_r <= 1'b1;
    end else if (go) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_ms_r <= in_tdata;
    end
  end

  // effect state; a register write of on/off wins over a word in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      level_r  <= '0;
      rising_r <= 1'b1;
    end else begin
      if (go) begin
        count_r  <= nxt.count;
        rising_r <= nxt.rising;
      end
      if (level_load.en) begin
        level_r <= level_load.value;
      end else if (go) begin
        level_r <= nxt.level;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (go) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_level_r <= nxt.level;
      out_upd_r   <= fired;
    end
  end

  assign out_tvalid   = out_v_r;
  assign out_tdata    = out_level_r;
  assign out_tuser[0] = out_upd_r;

  // ---------------------------------------------------------------- checks

  // input side only stalls behind a blocked result with a word already held
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (in_v_r && out_v_r && !out_tready))
    else $error("input stalled without a blocked result");

  // a fired action always restarts the elapsed counter
  assert property (@(posedge clk) disable iff (!rst_n)
    (go && fired) |=> (count_r == '0))
    else $error("counter not cleared after an action");

  // a blink toggle lands on zero or the max level
  assert property (@(posedge clk) disable iff (!rst_n)
    (go && fired && (cfg.mode == MODE_BLINK) && !level_load.en) |=>
      ((level_r == '0) || (level_r == $past(cfg.max_level))))
    else $error("blink level neither zero nor max");

  // a word leaves the input register only into the result register
  assert property (@(posedge clk) disable iff (!rst_n)
    go |=> (out_v_r && (out_level_r == level_r || $past(level_load.en) || level_load.en)))
    else $error("result does not match level state");

endmodule

`default_nettype wire
